FILE: hw/rtl/aalr_pkg.sv
// ----------------------------------------------------------------------------
// aalr_pkg
// Shared types for the antialiased line rasterizer: controller commands,
// datapath status and the result kind selector.
// ----------------------------------------------------------------------------
package aalr_pkg;

	// which result the datapath forms on an emit command
	typedef enum logic [1:0] {
		EMIT_FIRST,   // near endpoint, half coverage
		EMIT_MID,     // interior column from the accumulator
		EMIT_LAST,    // far endpoint, half coverage, last
		EMIT_SINGLE   // repeat of a degenerate point, last
	} emit_kind_t;

	typedef struct packed {
		logic       load;       // capture a segment
		logic       div_step;   // one restoring division step
		logic       slope_set;  // apply sign to the quotient
		logic       emit;       // load the output register
		emit_kind_t kind;
	} aalr_cmd_t;

	typedef struct packed {
		logic div_done;     // current division step is the final one
		logic dx_zero;      // both endpoints coincide
		logic at_end_next;  // next column is the far endpoint
		logic out_free;     // output register can take a result
	} aalr_status_t;

endpackage

FILE: hw/rtl/aalr_ctrl.sv
// ----------------------------------------------------------------------------
// aalr_ctrl
// Sequencer: accept a segment, run the gradient division, then step the
// columns one result per free output slot.
// ----------------------------------------------------------------------------
module aalr_ctrl
	import aalr_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	output logic         in_ready,
	input  aalr_status_t status,
	output aalr_cmd_t    cmd
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DIV    = 3'd1;
	localparam logic [2:0] ST_SLOPE  = 3'd2;
	localparam logic [2:0] ST_FIRST  = 3'd3;
	localparam logic [2:0] ST_MID    = 3'd4;
	localparam logic [2:0] ST_LAST   = 3'd5;
	localparam logic [2:0] ST_SINGLE = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_d;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd.load      = 1'b0;
		cmd.div_step  = 1'b0;
		cmd.slope_set = 1'b0;
		cmd.emit      = 1'b0;
		cmd.kind      = EMIT_FIRST;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (status.div_done) state_d = ST_SLOPE;
			end
			ST_SLOPE: begin
				cmd.slope_set = 1'b1;
				state_d       = ST_FIRST;
			end
			ST_FIRST: begin
				cmd.kind = EMIT_FIRST;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					priority if (status.dx_zero) state_d = ST_SINGLE;
					else if (status.at_end_next)  state_d = ST_LAST;
					else                          state_d = ST_MID;
				end
			end
			ST_MID: begin
				cmd.kind = EMIT_MID;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					if (status.at_end_next) state_d = ST_LAST;
				end
			end
			ST_LAST: begin
				cmd.kind = EMIT_LAST;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_SINGLE: begin
				cmd.kind = EMIT_SINGLE;
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hw/rtl/aalr_dpath.sv
// ----------------------------------------------------------------------------
// aalr_dpath
// Endpoint ordering, bit-serial gradient divider, minor-axis accumulator,
// coverage calculation and the output register.
// ----------------------------------------------------------------------------
module aalr_dpath
	import aalr_pkg::*;
#(
	parameter int COORD_BITS  = 6,
	parameter int FRAC_BITS   = 16,
	parameter int BRIGHT_BITS = 8
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [COORD_BITS-1:0]  x_start,
	input  logic [COORD_BITS-1:0]  y_start,
	input  logic [COORD_BITS-1:0]  x_finish,
	input  logic [COORD_BITS-1:0]  y_finish,
	input  aalr_cmd_t              cmd,
	output aalr_status_t           status,
	input  logic                   out_ready,
	output logic                   out_valid,
	output logic [COORD_BITS-1:0]  pix_x,
	output logic [COORD_BITS-1:0]  pix_y,
	output logic                   neighbor_on_x,
	output logic [BRIGHT_BITS-1:0] bright_first,
	output logic [BRIGHT_BITS-1:0] bright_second,
	output logic                   last
);

	localparam int C     = COORD_BITS;
	localparam int F     = FRAC_BITS;
	localparam int B     = BRIGHT_BITS;
	localparam int QW    = C + F;          // dividend / quotient width
	localparam int AW    = C + F + 1;      // signed accumulator width
	localparam int SW    = F + 2;          // signed slope width
	localparam int DCW   = $clog2(QW);

	// ---- endpoint ordering (combinational, on load) ----
	logic [C-1:0] adx, ady;
	logic         steep;
	logic [C-1:0] pa, qa, pb, qb;
	logic [C-1:0] maj_a, min_a, maj_b, min_b;

	always_comb begin
		adx   = (x_finish > x_start) ? (x_finish - x_start) : (x_start - x_finish);
		ady   = (y_finish > y_start) ? (y_finish - y_start) : (y_start - y_finish);
		steep = (ady > adx);
		if (steep) begin
			pa = y_start;  qa = x_start;
			pb = y_finish; qb = x_finish;
		end else begin
			pa = x_start;  qa = y_start;
			pb = x_finish; qb = y_finish;
		end
		if (pa > pb) begin
			maj_a = pb; min_a = qb;
			maj_b = pa; min_b = qa;
		end else begin
			maj_a = pa; min_a = qa;
			maj_b = pb; min_b = qb;
		end
	end

	logic [C-1:0] maj_a_q, min_a_q, maj_b_q, min_b_q, dx_q, col_q;
	logic         steep_q, neg_q;

	// ---- restoring divider: quotient = (|dy| << F) / dx ----
	logic [C:0]     rem_q;
	logic [QW-1:0]  quo_q;
	logic [DCW-1:0] div_cnt_q;
	logic [C:0]     trial;
	logic           qbit;

	assign trial = {rem_q[C-1:0], quo_q[QW-1]};
	assign qbit  = (trial >= {1'b0, dx_q});

	// ---- slope and accumulator ----
	logic signed [SW-1:0] slope_q;
	logic signed [AW-1:0] acc_q;
	logic signed [AW-1:0] slope_ext;
	logic signed [AW-1:0] acc_init;

	assign slope_ext = AW'(slope_q);
	assign acc_init  = $signed({1'b0, min_a_q, {F{1'b0}}}) + slope_ext;

	// ---- coverage of the current interior column ----
	logic [C+F-1:0] acc_pos;
	logic [F-1:0]   frac;
	logic [C-1:0]   ip;
	logic [F:0]     one_minus;
	logic [F+B:0]   b1_wide;
	logic [F+B-1:0] b2_wide;
	logic [B-1:0]   b1_mid, b2_mid;

	always_comb begin
		acc_pos   = acc_q[AW-1] ? '0 : acc_q[C+F-1:0];
		frac      = acc_pos[F-1:0];
		ip        = acc_pos[C+F-1:F];
		one_minus = {1'b1, {F{1'b0}}} - {1'b0, frac};
		b1_wide   = ({{B{1'b0}}, one_minus} << B) >> F;
		b2_wide   = ({{B{1'b0}}, frac} << B) >> F;
		b1_mid    = b1_wide[B] ? {B{1'b1}} : b1_wide[B-1:0];
		b2_mid    = b2_wide[B-1:0];
	end

	localparam logic [B-1:0] HALF = {1'b1, {(B-1){1'b0}}};

	// ---- result selection ----
	logic [C-1:0] sel_major, sel_minor;
	logic [B-1:0] sel_b1, sel_b2;
	logic         sel_last;

	always_comb begin
		unique case (cmd.kind)
			EMIT_FIRST: begin
				sel_major = maj_a_q; sel_minor = min_a_q;
				sel_b1 = HALF; sel_b2 = '0; sel_last = 1'b0;
			end
			EMIT_MID: begin
				sel_major = col_q; sel_minor = ip;
				sel_b1 = b1_mid; sel_b2 = b2_mid; sel_last = 1'b0;
			end
			EMIT_LAST: begin
				sel_major = maj_b_q; sel_minor = min_b_q;
				sel_b1 = HALF; sel_b2 = '0; sel_last = 1'b1;
			end
			EMIT_SINGLE: begin
				sel_major = maj_a_q; sel_minor = min_a_q;
				sel_b1 = HALF; sel_b2 = '0; sel_last = 1'b1;
			end
			default: begin
				sel_major = maj_a_q; sel_minor = min_a_q;
				sel_b1 = HALF; sel_b2 = '0; sel_last = 1'b0;
			end
		endcase
	end

	// ---- status ----
	logic [C:0] col_inc;
	assign col_inc            = {1'b0, col_q} + {{C{1'b0}}, 1'b1};
	assign status.div_done    = (div_cnt_q == DCW'(QW - 1));
	assign status.dx_zero     = (dx_q == '0);
	assign status.at_end_next = (col_inc == {1'b0, maj_b_q});
	assign status.out_free    = !out_valid || out_ready;

	// ---- segment, divider, slope and column registers ----
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			maj_a_q   <= maj_a;
			min_a_q   <= min_a;
			maj_b_q   <= maj_b;
			min_b_q   <= min_b;
			steep_q   <= steep;
			neg_q     <= (min_b < min_a);
			dx_q      <= maj_b - maj_a;
			col_q     <= maj_a;
			rem_q     <= '0;
			quo_q     <= {((min_b < min_a) ? (min_a - min_b) : (min_b - min_a)), {F{1'b0}}};
			div_cnt_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q     <= qbit ? (trial - {1'b0, dx_q}) : trial;
			quo_q     <= {quo_q[QW-2:0], qbit};
			div_cnt_q <= div_cnt_q + DCW'(1);
		end
		if (cmd.slope_set) begin
			slope_q <= neg_q ? -$signed({1'b0, quo_q[F:0]}) : $signed({1'b0, quo_q[F:0]});
		end
		if (cmd.emit) begin
			if (cmd.kind == EMIT_FIRST) begin
				col_q <= col_inc[C-1:0];
				acc_q <= acc_init;
			end else if (cmd.kind == EMIT_MID) begin
				col_q <= col_inc[C-1:0];
				acc_q <= acc_q + slope_ext;
			end
		end
	end

	// ---- output register ----
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pix_x         <= steep_q ? sel_minor : sel_major;
			pix_y         <= steep_q ? sel_major : sel_minor;
			neighbor_on_x <= steep_q;
			bright_first  <= sel_b1;
			bright_second <= sel_b2;
			last          <= sel_last;
		end
	end

endmodule

FILE: hw/rtl/antialiased_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// antialiased_line_rasterizer_unit
// Antialiased line rasterizer (Wu's algorithm) with a stream in and out.
// ----------------------------------------------------------------------------
// One segment in, one result per major-axis column out, lowest column first.
// Each result names the lower pixel of a pair (pix_x, pix_y), whether its
// neighbor sits at x+1 (steep line) or y+1, and both coverages, full scale
// 2^BRIGHT_BITS-1. Endpoint columns get half coverage. Coincident endpoints
// give two half-coverage results for the same pixel, the second one last.
// Per segment: capture, a bit-serial gradient division, signing of the
// slope, then one result per cycle while the sink takes them: dx+1
// results, or 2 for a single point. s_tready is high only between
// segments; results sit in an output register so the last one may still
// wait while the next segment is taken.
// ----------------------------------------------------------------------------
module antialiased_line_rasterizer_unit
	import aalr_pkg::*;
#(
	parameter int COORD_BITS  = 6,
	parameter int FRAC_BITS   = 16,
	parameter int BRIGHT_BITS = 8
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                                         s_tvalid,
	output logic                                         s_tready,
	// x_start, y_start, x_finish, y_finish (COORD_BITS each), zero padding
	input  logic [((4*COORD_BITS+7)/8)*8-1:0]            s_tdata,

	output logic                                         m_tvalid,
	input  logic                                         m_tready,
	// pix_x, pix_y (COORD_BITS), bright_first, bright_second (BRIGHT_BITS),
	// zero padding
	output logic [((2*COORD_BITS+2*BRIGHT_BITS+7)/8)*8-1:0] m_tdata,
	// neighbor_on_x
	output logic                                         m_tuser,
	output logic                                         m_tlast
);

	localparam int C     = COORD_BITS;
	localparam int B     = BRIGHT_BITS;
	localparam int OUT_W = ((2*C+2*B+7)/8)*8;

	aalr_cmd_t    cmd;
	aalr_status_t status;

	logic [C-1:0] pix_x, pix_y;
	logic [B-1:0] bright_first, bright_second;

	// sequencer
	aalr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// ordering, divider, accumulator, output register
	aalr_dpath #(
		.COORD_BITS  (COORD_BITS),
		.FRAC_BITS   (FRAC_BITS),
		.BRIGHT_BITS (BRIGHT_BITS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.x_start       (s_tdata[C-1:0]),
		.y_start       (s_tdata[2*C-1:C]),
		.x_finish      (s_tdata[3*C-1:2*C]),
		.y_finish      (s_tdata[4*C-1:3*C]),
		.cmd           (cmd),
		.status        (status),
		.out_ready     (m_tready),
		.out_valid     (m_tvalid),
		.pix_x         (pix_x),
		.pix_y         (pix_y),
		.neighbor_on_x (m_tuser),
		.bright_first  (bright_first),
		.bright_second (bright_second),
		.last          (m_tlast)
	);

	assign m_tdata = OUT_W'({bright_second, bright_first, pix_y, pix_x});

endmodule
